@@ rtl/tat_pkg.sv @@
package tat_pkg;

	// Field widths
	localparam int unsigned COORD_W = 32;
	localparam int unsigned RANGE_W = 31;
	localparam int unsigned TOL_W   = 16;

	// Tolerance after reset: 0.01 m in Q16.16
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_PIVOT = 2'd1,
		ST_PARALLEL = 2'd2,
		ST_SAT      = 2'd3
	} status_t;

endpackage

@@ rtl/three_antenna_trilateration.sv @@
// Three antenna 2D position fix, signed Q16.16 metres.
// Slave stream (s_tvalid/s_tready/s_tdata) carries one antenna set per item:
// positions and ranges of antennas i, j and k. Master stream
// (m_tvalid/m_tready/m_tdata) returns one result item per input item, in
// order: pos_x, pos_y and a status code (ok, no pivot antenna, parallel
// lines, saturated). The tolerance register is written through cfg_valid /
// cfg_data, which is always ready; write it only while the block is idle.
// The path from acceptance to m_tvalid has 11 arithmetic stages
// (pivot choice, squares, split 33x65 products, magnitudes) followed by a
// 32-stage restoring divider, one quotient bit per stage, and the output
// register. Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls with a result waiting, the whole pipeline holds,
// bubbles included, and s_tready follows m_tready.
// Reset clears all valid bits and loads the tolerance with 655 (0.01 m);
// no clearing pass is needed, the block accepts items right after reset.
module three_antenna_trilateration (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration: tolerance register
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tat_pkg::TOL_W-1:0]  cfg_data,
	// antenna set in
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// low to high: ant_i_x, ant_i_y, range_i, ant_j_x, ant_j_y, range_j,
	// ant_k_x, ant_k_y, range_k, zero pad
	input  logic [287:0]               s_tdata,
	// position out
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// low to high: pos_x, pos_y, status, zero pad
	output logic [71:0]                m_tdata
);
	import tat_pkg::*;

	localparam int unsigned NDIV = 32;
	localparam int unsigned NST  = 12 + NDIV;

	logic               en;
	logic [NST:1]       vld_q;
	logic [TOL_W-1:0]   tol_q;

	// Whole pipeline advances unless a result waits unread
	assign en        = m_tready | ~vld_q[NST];
	assign s_tready  = en;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = vld_q[NST];

	// Tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_valid) begin
			tol_q <= cfg_data;
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-1:1], s_tvalid};
		end
	end

	// ---------------- stage 1: pivot choice ----------------
	logic signed [COORD_W-1:0] xi, yi, xj, yj, xk, yk;
	logic [RANGE_W-1:0]        ri, rj, rk;
	logic signed [COORD_W:0]   dij, djk, dki;
	logic [COORD_W:0]          mij, mjk, mki, tol_e;
	logic                      gij, gjk, gki;

	assign xi = s_tdata[31:0];
	assign yi = s_tdata[63:32];
	assign ri = s_tdata[94:64];
	assign xj = s_tdata[126:95];
	assign yj = s_tdata[158:127];
	assign rj = s_tdata[189:159];
	assign xk = s_tdata[221:190];
	assign yk = s_tdata[253:222];
	assign rk = s_tdata[284:254];

	always_comb begin
		tol_e = (tol_q == '0) ? (COORD_W+1)'(1) : (COORD_W+1)'(tol_q);
		dij = (COORD_W+1)'(xi) - (COORD_W+1)'(xj);
		djk = (COORD_W+1)'(xj) - (COORD_W+1)'(xk);
		dki = (COORD_W+1)'(xk) - (COORD_W+1)'(xi);
		mij = dij[COORD_W] ? -dij : dij;
		mjk = djk[COORD_W] ? -djk : djk;
		mki = dki[COORD_W] ? -dki : dki;
		gij = mij >= tol_e;
		gjk = mjk >= tol_e;
		gki = mki >= tol_e;
	end

	logic signed [COORD_W-1:0] xp_s1, yp_s1, xa_s1, ya_s1, xb_s1, yb_s1;
	logic [RANGE_W-1:0]        rp_s1, ra_s1, rb_s1;
	logic                      nopiv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			nopiv_s1 <= 1'b0;
			if (gij && gki) begin
				xp_s1 <= xi; yp_s1 <= yi; rp_s1 <= ri;
				xa_s1 <= xj; ya_s1 <= yj; ra_s1 <= rj;
				xb_s1 <= xk; yb_s1 <= yk; rb_s1 <= rk;
			end else if (gij && gjk) begin
				xp_s1 <= xj; yp_s1 <= yj; rp_s1 <= rj;
				xa_s1 <= xk; ya_s1 <= yk; ra_s1 <= rk;
				xb_s1 <= xi; yb_s1 <= yi; rb_s1 <= ri;
			end else begin
				xp_s1 <= xk; yp_s1 <= yk; rp_s1 <= rk;
				xa_s1 <= xi; ya_s1 <= yi; ra_s1 <= ri;
				xb_s1 <= xj; yb_s1 <= yj; rb_s1 <= rj;
				nopiv_s1 <= !(gki && gjk);
			end
		end
	end

	// ---------------- stage 2: differences and magnitudes ----------------
	logic signed [COORD_W:0] dx1_s2, dy1_s2, dx2_s2, dy2_s2;
	logic [COORD_W-1:0]      axp_s2, ayp_s2, axa_s2, aya_s2, axb_s2, ayb_s2;
	logic [RANGE_W-1:0]      rp_s2, ra_s2, rb_s2;
	logic                    nopiv_s2;

	function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
		logic [COORD_W-1:0] m;
		m = v[COORD_W-1] ? (~v + 1'b1) : v;
		return m;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			dx1_s2   <= (COORD_W+1)'(xp_s1) - (COORD_W+1)'(xa_s1);
			dy1_s2   <= (COORD_W+1)'(ya_s1) - (COORD_W+1)'(yp_s1);
			dx2_s2   <= (COORD_W+1)'(xp_s1) - (COORD_W+1)'(xb_s1);
			dy2_s2   <= (COORD_W+1)'(yb_s1) - (COORD_W+1)'(yp_s1);
			axp_s2   <= mag32(xp_s1);
			ayp_s2   <= mag32(yp_s1);
			axa_s2   <= mag32(xa_s1);
			aya_s2   <= mag32(ya_s1);
			axb_s2   <= mag32(xb_s1);
			ayb_s2   <= mag32(yb_s1);
			rp_s2    <= rp_s1;
			ra_s2    <= ra_s1;
			rb_s2    <= rb_s1;
			nopiv_s2 <= nopiv_s1;
		end
	end

	// ---------------- stage 3: squares and slope products ----------------
	logic [63:0]             sxp_s3, syp_s3, sxa_s3, sya_s3, sxb_s3, syb_s3;
	logic [61:0]             srp_s3, sra_s3, srb_s3;
	logic signed [65:0]      pd1_s3, pd2_s3;
	logic signed [COORD_W:0] dx1_s3, dy1_s3, dx2_s3, dy2_s3;
	logic                    nopiv_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sxp_s3   <= axp_s2 * axp_s2;
			syp_s3   <= ayp_s2 * ayp_s2;
			sxa_s3   <= axa_s2 * axa_s2;
			sya_s3   <= aya_s2 * aya_s2;
			sxb_s3   <= axb_s2 * axb_s2;
			syb_s3   <= ayb_s2 * ayb_s2;
			srp_s3   <= rp_s2 * rp_s2;
			sra_s3   <= ra_s2 * ra_s2;
			srb_s3   <= rb_s2 * rb_s2;
			pd1_s3   <= dy1_s2 * dx2_s2;
			pd2_s3   <= dx1_s2 * dy2_s2;
			dx1_s3   <= dx1_s2;
			dy1_s3   <= dy1_s2;
			dx2_s3   <= dx2_s2;
			dy2_s3   <= dy2_s2;
			nopiv_s3 <= nopiv_s2;
		end
	end

	// ---------------- stage 4: circle sums and determinant ----------------
	logic [63:0]             pos1_s4, neg1_s4, pos2_s4, neg2_s4;
	logic signed [66:0]      det_s4;
	logic signed [COORD_W:0] dx1_s4, dy1_s4, dx2_s4, dy2_s4;
	logic                    nopiv_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pos1_s4  <= sxp_s3 + syp_s3 + 64'(sra_s3);
			neg1_s4  <= sxa_s3 + sya_s3 + 64'(srp_s3);
			pos2_s4  <= sxp_s3 + syp_s3 + 64'(srb_s3);
			neg2_s4  <= sxb_s3 + syb_s3 + 64'(srp_s3);
			det_s4   <= 67'(pd1_s3) - 67'(pd2_s3);
			dx1_s4   <= dx1_s3;
			dy1_s4   <= dy1_s3;
			dx2_s4   <= dx2_s3;
			dy2_s4   <= dy2_s3;
			nopiv_s4 <= nopiv_s3;
		end
	end

	// ---------------- stage 5: circle differences ----------------
	logic signed [64:0]      n1_s5, n2_s5;
	logic signed [66:0]      det_s5;
	logic signed [COORD_W:0] dx1_s5, dy1_s5, dx2_s5, dy2_s5;
	logic                    nopiv_s5, par_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s5    <= $signed({1'b0, pos1_s4}) - $signed({1'b0, neg1_s4});
			n2_s5    <= $signed({1'b0, pos2_s4}) - $signed({1'b0, neg2_s4});
			det_s5   <= det_s4;
			par_s5   <= det_s4 == '0;
			dx1_s5   <= dx1_s4;
			dy1_s5   <= dy1_s4;
			dx2_s5   <= dx2_s4;
			dy2_s5   <= dy2_s4;
			nopiv_s5 <= nopiv_s4;
		end
	end

	// ---------------- stage 6: partial products, n split at bit 33 ----------------
	logic signed [33:0] n1l, n2l;
	logic signed [31:0] n1h, n2h;

	assign n1l = $signed({1'b0, n1_s5[32:0]});
	assign n2l = $signed({1'b0, n2_s5[32:0]});
	assign n1h = n1_s5[64:33];
	assign n2h = n2_s5[64:33];

	logic signed [66:0] pxal_s6, pxbl_s6, pyal_s6, pybl_s6;
	logic signed [64:0] pxah_s6, pxbh_s6, pyah_s6, pybh_s6;
	logic signed [66:0] det_s6;
	logic               nopiv_s6, par_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			pxal_s6  <= dy1_s5 * n2l;
			pxah_s6  <= dy1_s5 * n2h;
			pxbl_s6  <= dy2_s5 * n1l;
			pxbh_s6  <= dy2_s5 * n1h;
			pyal_s6  <= dx1_s5 * n2l;
			pyah_s6  <= dx1_s5 * n2h;
			pybl_s6  <= dx2_s5 * n1l;
			pybh_s6  <= dx2_s5 * n1h;
			det_s6   <= det_s5;
			nopiv_s6 <= nopiv_s5;
			par_s6   <= par_s5;
		end
	end

	// ---------------- stage 7: recombine partial products ----------------
	logic signed [97:0] pxa_s7, pxb_s7, pya_s7, pyb_s7;
	logic signed [66:0] det_s7;
	logic               nopiv_s7, par_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pxa_s7   <= $signed({pxah_s6, 33'd0}) + 98'(pxal_s6);
			pxb_s7   <= $signed({pxbh_s6, 33'd0}) + 98'(pxbl_s6);
			pya_s7   <= $signed({pyah_s6, 33'd0}) + 98'(pyal_s6);
			pyb_s7   <= $signed({pybh_s6, 33'd0}) + 98'(pybl_s6);
			det_s7   <= det_s6;
			nopiv_s7 <= nopiv_s6;
			par_s7   <= par_s6;
		end
	end

	// ---------------- stage 8: numerators ----------------
	logic signed [98:0] numx_s8, numy_s8;
	logic signed [66:0] det_s8;
	logic               nopiv_s8, par_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s8  <= 99'(pxa_s7) - 99'(pxb_s7);
			numy_s8  <= 99'(pya_s7) - 99'(pyb_s7);
			det_s8   <= det_s7;
			nopiv_s8 <= nopiv_s7;
			par_s8   <= par_s7;
		end
	end

	// ---------------- stage 9: magnitudes and signs ----------------
	logic [97:0] anx_s9, any_s9;
	logic [65:0] adet_s9;
	logic        negx_s9, negy_s9, nopiv_s9, par_s9;
	logic signed [98:0] nnx, nny;
	logic signed [66:0] ndet;

	assign nnx  = -numx_s8;
	assign nny  = -numy_s8;
	assign ndet = -det_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			anx_s9   <= numx_s8[98] ? nnx[97:0] : numx_s8[97:0];
			any_s9   <= numy_s8[98] ? nny[97:0] : numy_s8[97:0];
			adet_s9  <= det_s8[66] ? ndet[65:0] : det_s8[65:0];
			negx_s9  <= numx_s8[98] ^ det_s8[66];
			negy_s9  <= numy_s8[98] ^ det_s8[66];
			nopiv_s9 <= nopiv_s8;
			par_s9   <= par_s8;
		end
	end

	// ---------------- stage 10: rounding dividend and divisor ----------------
	// q = (2|num| + |2det|) / (2|2det|), nearest with ties away from zero
	logic [99:0] nx_s10, ny_s10;
	logic [67:0] dv_s10;
	logic        negx_s10, negy_s10, nopiv_s10, par_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s10    <= {(99'(anx_s9) + 99'(adet_s9)), 1'b0};
			ny_s10    <= {(99'(any_s9) + 99'(adet_s9)), 1'b0};
			dv_s10    <= {adet_s9, 2'b00};
			negx_s10  <= negx_s9;
			negy_s10  <= negy_s9;
			nopiv_s10 <= nopiv_s9;
			par_s10   <= par_s9;
		end
	end

	// ---------------- stage 11: quotient overflow check ----------------
	logic [99:0] nx_s11, ny_s11;
	logic [67:0] dv_s11;
	logic        ovx_s11, ovy_s11, negx_s11, negy_s11, nopiv_s11, par_s11;
	logic [99:0] dv_top;

	assign dv_top = {dv_s10, 32'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s11    <= nx_s10;
			ny_s11    <= ny_s10;
			dv_s11    <= dv_s10;
			ovx_s11   <= nx_s10 >= dv_top;
			ovy_s11   <= ny_s10 >= dv_top;
			negx_s11  <= negx_s10;
			negy_s11  <= negy_s10;
			nopiv_s11 <= nopiv_s10;
			par_s11   <= par_s10;
		end
	end

	// ---------------- divider: one quotient bit per stage ----------------
	typedef struct packed {
		logic ovx;
		logic ovy;
		logic negx;
		logic negy;
		logic nopiv;
		logic par;
	} flags_t;

	logic [99:0]        rx_d [0:NDIV];
	logic [99:0]        ry_d [0:NDIV];
	logic [NDIV-1:0]    qx_d [0:NDIV];
	logic [NDIV-1:0]    qy_d [0:NDIV];
	logic [67:0]        dv_d [0:NDIV];
	flags_t             fl_d [0:NDIV];

	assign rx_d[0] = nx_s11;
	assign ry_d[0] = ny_s11;
	assign qx_d[0] = '0;
	assign qy_d[0] = '0;
	assign dv_d[0] = dv_s11;
	assign fl_d[0] = '{ovx: ovx_s11, ovy: ovy_s11, negx: negx_s11, negy: negy_s11,
		nopiv: nopiv_s11, par: par_s11};

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		localparam int unsigned B = NDIV - 1 - k;
		logic [99:0] sh;
		logic [99:0] rx_q, ry_q;
		logic [NDIV-1:0] qx_q, qy_q;
		logic [67:0] dv_q;
		flags_t fl_q;

		assign sh = 100'(dv_d[k]) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rx_d[k] >= sh) begin
					rx_q <= rx_d[k] - sh;
					qx_q <= qx_d[k] | (NDIV'(1) << B);
				end else begin
					rx_q <= rx_d[k];
					qx_q <= qx_d[k];
				end
				if (ry_d[k] >= sh) begin
					ry_q <= ry_d[k] - sh;
					qy_q <= qy_d[k] | (NDIV'(1) << B);
				end else begin
					ry_q <= ry_d[k];
					qy_q <= qy_d[k];
				end
				dv_q <= dv_d[k];
				fl_q <= fl_d[k];
			end
		end

		assign rx_d[k+1] = rx_q;
		assign ry_d[k+1] = ry_q;
		assign qx_d[k+1] = qx_q;
		assign qy_d[k+1] = qy_q;
		assign dv_d[k+1] = dv_q;
		assign fl_d[k+1] = fl_q;
	end

	// ---------------- output stage: clamp, sign and status ----------------
	logic [NDIV-1:0]   limx, limy, mx, my;
	logic              satx, saty;
	logic [COORD_W-1:0] pos_x_q, pos_y_q;
	status_t           status_q;
	flags_t            flo;

	assign flo  = fl_d[NDIV];
	assign limx = flo.negx ? 32'h8000_0000 : 32'h7fff_ffff;
	assign limy = flo.negy ? 32'h8000_0000 : 32'h7fff_ffff;
	assign satx = flo.ovx | (qx_d[NDIV] > limx);
	assign saty = flo.ovy | (qy_d[NDIV] > limy);
	assign mx   = satx ? limx : qx_d[NDIV];
	assign my   = saty ? limy : qy_d[NDIV];

	always_ff @(posedge clk) begin
		if (en) begin
			if (flo.nopiv) begin
				pos_x_q  <= '0;
				pos_y_q  <= '0;
				status_q <= ST_NO_PIVOT;
			end else if (flo.par) begin
				pos_x_q  <= '0;
				pos_y_q  <= '0;
				status_q <= ST_PARALLEL;
			end else begin
				pos_x_q  <= flo.negx ? (~mx + 1'b1) : mx;
				pos_y_q  <= flo.negy ? (~my + 1'b1) : my;
				status_q <= (satx | saty) ? ST_SAT : ST_OK;
			end
		end
	end

	assign m_tdata = {6'd0, status_q, pos_y_q, pos_x_q};

	// ---------------- checks ----------------
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_q == ST_NO_PIVOT || status_q == ST_PARALLEL)
		|-> pos_x_q == '0 && pos_y_q == '0)
		else $error("failed fix carries a nonzero position");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status_q == ST_SAT
		|-> pos_x_q == 32'h7fff_ffff || pos_x_q == 32'h8000_0000 ||
		    pos_y_q == 32'h7fff_ffff || pos_y_q == 32'h8000_0000)
		else $error("saturated result without a clamped coordinate");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a stall");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NST] |-> s_tready)
		else $error("input held off with an empty output stage");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import tat_pkg::*;

	typedef struct {
		logic signed [31:0] x [3];
		logic signed [31:0] y [3];
		logic [30:0]        r [3];
	} ant_set_t;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		status_t     st;
	} fix_t;

	localparam int LIMIT_CYCLES = 400000;
	localparam int LATENCY      = 44;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [TOL_W-1:0]   cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [287:0]       s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [71:0]        m_tdata;

	logic [TOL_W-1:0]   tol_reg;
	fix_t               fix_q [$];
	int                 errors;
	int                 cycles;
	bit                 no_idle;

	three_antenna_trilateration uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// rounded quotient, ties away from zero, clamped to 32 bits
	function automatic logic [31:0] div_round(input logic signed [127:0] num,
		input logic signed [127:0] den, inout bit sat);
		bit                 neg;
		logic [127:0]       mn, md, q, lim;
		neg = (num < 0) != (den < 0);
		mn  = (num < 0) ? -num : num;
		md  = (den < 0) ? -den : den;
		q   = (2 * mn + md) / (2 * md);
		lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		if (q > lim) begin
			q   = lim;
			sat = 1'b1;
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	// expected fix for one antenna set
	function automatic fix_t solve_fix(input ant_set_t a, input logic [TOL_W-1:0] tr);
		fix_t               f;
		longint             tol, d1, d2;
		int                 p, ia, ib;
		logic signed [127:0] xp, yp, rp, xa, ya, ra, xb, yb, rb;
		logic signed [127:0] dx1, dy1, dx2, dy2, n1, n2, det, nx, ny;
		bit                 sat;
		tol  = (tr == 0) ? 1 : longint'(tr);
		p    = -1;
		f.px = '0;
		f.py = '0;
		sat  = 1'b0;
		for (int n = 0; n < 3; n++) begin
			d1 = longint'(a.x[n]) - longint'(a.x[(n + 1) % 3]);
			d2 = longint'(a.x[n]) - longint'(a.x[(n + 2) % 3]);
			if (d1 < 0) d1 = -d1;
			if (d2 < 0) d2 = -d2;
			if (p < 0 && d1 >= tol && d2 >= tol) p = n;
		end
		if (p < 0) begin
			f.st = ST_NO_PIVOT;
			return f;
		end
		ia = (p + 1) % 3;
		ib = (p + 2) % 3;
		xp = 128'(a.x[p]);  yp = 128'(a.y[p]);  rp = 128'($signed({1'b0, a.r[p]}));
		xa = 128'(a.x[ia]); ya = 128'(a.y[ia]); ra = 128'($signed({1'b0, a.r[ia]}));
		xb = 128'(a.x[ib]); yb = 128'(a.y[ib]); rb = 128'($signed({1'b0, a.r[ib]}));
		dx1 = xp - xa; dy1 = ya - yp;
		dx2 = xp - xb; dy2 = yb - yp;
		n1 = xp * xp - xa * xa + yp * yp - ya * ya - rp * rp + ra * ra;
		n2 = xp * xp - xb * xb + yp * yp - yb * yb - rp * rp + rb * rb;
		det = dy1 * dx2 - dx1 * dy2;
		if (det == 0) begin
			f.st = ST_PARALLEL;
			return f;
		end
		det  = 2 * det;
		nx   = dy1 * n2 - dy2 * n1;
		ny   = dx1 * n2 - dx2 * n1;
		f.px = div_round(nx, det, sat);
		f.py = div_round(ny, det, sat);
		f.st = sat ? ST_SAT : ST_OK;
		return f;
	endfunction

	function automatic logic [287:0] pack_set(input ant_set_t a);
		logic [287:0] d;
		d = '0;
		for (int n = 0; n < 3; n++) begin
			d[95 * n +: 32]      = a.x[n];
			d[95 * n + 32 +: 32] = a.y[n];
			d[95 * n + 64 +: 31] = a.r[n];
		end
		return d;
	endfunction

	function automatic ant_set_t unpack_set(input logic [287:0] d);
		ant_set_t a;
		for (int n = 0; n < 3; n++) begin
			a.x[n] = d[95 * n +: 32];
			a.y[n] = d[95 * n + 32 +: 32];
			a.r[n] = d[95 * n + 64 +: 31];
		end
		return a;
	endfunction

	// signed value spanning the given number of bits
	function automatic logic signed [31:0] rnd_coord(input int bits);
		logic signed [31:0] v;
		v = $urandom;
		return v >>> (32 - bits);
	endfunction

	// input side: predict on every accepted item, track register writes
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			fix_q.push_back(solve_fix(unpack_set(s_tdata), tol_reg));
		if (arst_n && cfg_valid && cfg_ready)
			tol_reg <= cfg_data;
	end

	// output side: compare each result with the oldest prediction
	always @(posedge clk) begin
		fix_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (fix_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, m_tdata);
				errors++;
			end else begin
				e = fix_q.pop_front();
				if (m_tdata[31:0] !== e.px) begin
					$display("%0t: pos_x exp %h got %h", $time, e.px, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== e.py) begin
					$display("%0t: pos_y exp %h got %h", $time, e.py, m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[65:64] !== e.st) begin
					$display("%0t: status exp %0d got %0d", $time, e.st, m_tdata[65:64]);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		m_tready <= no_idle || ($urandom_range(0, 99) >= 14);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic send_set(input ant_set_t a);
		while (!no_idle && $urandom_range(0, 99) < 14) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = pack_set(a);
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_idle();
		while (fix_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_tol(input logic [TOL_W-1:0] v);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data  = v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic ant_set_t make_set(input int x0, y0, r0, x1, y1, r1,
		x2, y2, r2);
		ant_set_t a;
		a.x[0] = x0; a.y[0] = y0; a.r[0] = 31'(r0);
		a.x[1] = x1; a.y[1] = y1; a.r[1] = 31'(r1);
		a.x[2] = x2; a.y[2] = y2; a.r[2] = 31'(r2);
		return a;
	endfunction

	// random set, mostly plausible geometry, some degenerate and raw noise
	function automatic ant_set_t rnd_set();
		ant_set_t a;
		int       kind, bits, step;
		kind = $urandom_range(0, 99);
		bits = $urandom_range(8, 32);
		for (int n = 0; n < 3; n++) begin
			a.x[n] = rnd_coord(bits);
			a.y[n] = rnd_coord(bits);
			a.r[n] = 31'($urandom >> (32 - (bits > 31 ? 31 : bits)));
		end
		if (kind < 15) begin
			for (int n = 0; n < 3; n++) begin
				a.x[n] = $urandom;
				a.y[n] = $urandom;
				a.r[n] = 31'($urandom);
			end
		end else if (kind < 27) begin
			// x values close together: pivot search fails or is marginal
			a.x[1] = a.x[0] + $signed($urandom_range(0, 1400)) - 700;
			if (kind < 21) a.x[2] = a.x[0] + $signed($urandom_range(0, 1400)) - 700;
		end else if (kind < 37) begin
			// collinear antennas: parallel lines
			step   = $urandom_range(1, 1 << 16);
			a.x[1] = a.x[0] + step;
			a.y[1] = a.y[0] + 3 * step;
			a.x[2] = a.x[0] - 2 * step;
			a.y[2] = a.y[0] - 6 * step;
		end else if (kind < 42) begin
			// nearly collinear and far: drives the fix out of range
			a.x[0] = 0;       a.y[0] = 0;
			a.x[1] = 1 << 16; a.y[1] = 1 << 16;
			a.x[2] = 2 << 16; a.y[2] = (2 << 16) + 1;
			a.r[1] = 31'($urandom);
		end
		return a;
	endfunction

	task automatic test_directed();
		send_set(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_set(make_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF));
		send_set(make_set(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			0, 32'h7FFF_FFFF, 0));
		// regular fix: vehicle near (-0.08, 3.55) m
		send_set(make_set(0, 0, 5 << 16, 10 << 16, 0, 32'h000B_3F81,
			0, 10 << 16, 32'h0007_5A50));
		send_set(make_set(1 << 16, 2 << 16, 3 << 16, -(4 << 16), 5 << 16, 6 << 16,
			7 << 16, -(8 << 16), 9 << 16));
		// no pivot: all x within the tolerance; then x spaced at exactly the tolerance, which still gives a pivot
		send_set(make_set(100, 0, 0, 200, 1 << 16, 0, 654, 2 << 16, 0));
		send_set(make_set(0, 0, 0, 655, 0, 0, 1310, 0, 0));
		// pivot found only at the second or third antenna
		send_set(make_set(0, 0, 1, 100, 1 << 16, 2, 5 << 16, 3 << 16, 3));
		send_set(make_set(0, 0, 1, 5 << 16, 1 << 16, 2, 100, 3 << 16, 3));
		// parallel lines
		send_set(make_set(0, 0, 1 << 16, 1 << 16, 1 << 16, 2 << 16,
			2 << 16, 2 << 16, 3 << 16));
		send_set(make_set(0, 5, 0, 1 << 16, 5, 0, 2 << 16, 5, 0));
		// saturation; the last two sets give no pivot (x within the tolerance)
		send_set(make_set(0, 0, 0, 1 << 16, 1 << 16, 32'h7FFF_FFFF,
			2 << 16, (2 << 16) + 1, 0));
		send_set(make_set(0, 0, 32'h7FFF_FFFF, 1, 1, 0, 2, 3, 0));
		send_set(make_set(0, 0, 0, -1, 0, 32'h7FFF_FFFF, 1, 1, 0));
	endtask

	task automatic test_zero_tolerance();
		write_tol('0);
		send_set(make_set(0, 0, 1 << 16, 1, 1 << 16, 0, 2, 3 << 16, 1 << 16));
		send_set(make_set(7, 0, 0, 7, 1, 0, 9, 2, 0));
		send_set(make_set(-1, 0, 5, 0, 2, 9, 1, 7, 3));
	endtask

	task automatic test_max_tolerance();
		write_tol('1);
		send_set(make_set(0, 0, 0, 65535, 1 << 16, 0, -65535, 2 << 16, 0));
		send_set(make_set(0, 0, 0, 65534, 1 << 16, 0, -65535, 2 << 16, 0));
		send_set(make_set(0, 0, 3, 1 << 20, 5 << 16, 0, -(1 << 20), 2 << 16, 9));
	endtask

	task automatic test_random(input int count, input logic [TOL_W-1:0] tol_val);
		write_tol(tol_val);
		for (int i = 0; i < count; i++) begin
			no_idle = (i >= count / 3) && (i < count / 3 + 60);
			send_set(rnd_set());
		end
		no_idle = 1'b0;
	endtask

	task automatic test_pause();
		for (int i = 0; i < 20; i++) send_set(rnd_set());
		while (fix_q.size() != 0) @(negedge clk);
		for (int i = 0; i < 20; i++) send_set(rnd_set());
	endtask

	initial begin
		errors    = 0;
		cycles    = 0;
		no_idle   = 1'b0;
		tol_reg   = TOL_RESET;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_zero_tolerance();
		test_max_tolerance();
		test_random(300, TOL_RESET);
		test_pause();
		test_random(250, 16'd1);
		test_random(150, 16'($urandom));
		test_random(120, '1);
		test_random(80, '0);

		while (fix_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
